@@ rtl/lr_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, register indexes and width helpers for the line rasterizer.
// Depends on nothing; every other file of the block imports it.
package lr_pkg;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_COORD_BITS  = 6;
   localparam int DEF_BYTES_PER_PIXEL = 3;

   // Fixed field widths.
   localparam int ADDR_W    = 14;
   localparam int COLOR_W   = 8;
   localparam int CSR_IDX_W = 3;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CANVAS_WIDTH  = 3'd0,
      REG_CANVAS_HEIGHT = 3'd1,
      REG_PEN_RED       = 3'd2,
      REG_PEN_GREEN     = 3'd3,
      REG_PEN_BLUE      = 3'd4
   } csr_reg_type;

   // Width of the configuration write data: wide enough for a canvas size
   // register and for a color component.
   function automatic int csr_data_w(input int coord_bits);
      int canvas_bits;
      canvas_bits = coord_bits + 1;
      return (canvas_bits > COLOR_W) ? canvas_bits : COLOR_W;
   endfunction

endpackage

@@ rtl/lr_csr.sv @@
`timescale 1ns / 1ps
// Configuration registers: canvas size, precomputed column stride and pen color.
// Depends on lr_pkg.
module lr_csr import lr_pkg::*; #(
   parameter int MAX_COORD_BITS  = DEF_MAX_COORD_BITS,
   parameter int BYTES_PER_PIXEL = DEF_BYTES_PER_PIXEL
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [CSR_IDX_W-1:0]                   csr_index,
   input  logic [csr_data_w(MAX_COORD_BITS)-1:0]  csr_wdata,
   output logic [MAX_COORD_BITS:0]                canvas_width,
   output logic [MAX_COORD_BITS:0]                canvas_height,
   output logic [MAX_COORD_BITS+2:0]              column_stride,
   output logic [COLOR_W-1:0]                     pen_red,
   output logic [COLOR_W-1:0]                     pen_green,
   output logic [COLOR_W-1:0]                     pen_blue
);

   localparam int CANVAS_W = MAX_COORD_BITS + 1;
   localparam int STRIDE_W = MAX_COORD_BITS + 3;
   localparam logic [CANVAS_W-1:0] CANVAS_RESET = CANVAS_W'(1) << MAX_COORD_BITS;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET =
      STRIDE_W'(BYTES_PER_PIXEL) * (STRIDE_W'(1) << MAX_COORD_BITS);

   logic [CANVAS_W-1:0] width_ff, width_in;
   logic [CANVAS_W-1:0] height_ff, height_in;
   logic [STRIDE_W-1:0] stride_ff, stride_in;
   logic [COLOR_W-1:0]  red_ff, red_in;
   logic [COLOR_W-1:0]  green_ff, green_in;
   logic [COLOR_W-1:0]  blue_ff, blue_in;
   logic                write_en;

   // Writes are always taken; an unknown index is dropped.
   assign csr_ready = 1'b1;
   assign write_en  = csr_valid & csr_ready;

   // Register decode. The stride is the height scaled by the pixel size.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      stride_in = stride_ff;
      red_in    = red_ff;
      green_in  = green_ff;
      blue_in   = blue_ff;
      if (write_en) begin
         case (csr_index)
            REG_CANVAS_WIDTH: begin
               width_in = csr_wdata[CANVAS_W-1:0];
            end
            REG_CANVAS_HEIGHT: begin
               height_in = csr_wdata[CANVAS_W-1:0];
               stride_in = STRIDE_W'(BYTES_PER_PIXEL) * STRIDE_W'(csr_wdata[CANVAS_W-1:0]);
            end
            REG_PEN_RED: begin
               red_in = csr_wdata[COLOR_W-1:0];
            end
            REG_PEN_GREEN: begin
               green_in = csr_wdata[COLOR_W-1:0];
            end
            REG_PEN_BLUE: begin
               blue_in = csr_wdata[COLOR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CANVAS_RESET;
         height_ff <= CANVAS_RESET;
         stride_ff <= STRIDE_RESET;
         red_ff    <= '0;
         green_ff  <= '0;
         blue_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         stride_ff <= stride_in;
         red_ff    <= red_in;
         green_ff  <= green_in;
         blue_ff   <= blue_in;
      end
   end

   assign canvas_width  = width_ff;
   assign canvas_height = height_ff;
   assign column_stride = stride_ff;
   assign pen_red       = red_ff;
   assign pen_green     = green_ff;
   assign pen_blue      = blue_ff;

endmodule

@@ rtl/lr_addr.sv @@
`timescale 1ns / 1ps
// Pixel address and clip unit, shared by the end pixel and every walk pixel.
// Depends on lr_pkg.
module lr_addr import lr_pkg::*; #(
   parameter int MAX_COORD_BITS  = DEF_MAX_COORD_BITS,
   parameter int BYTES_PER_PIXEL = DEF_BYTES_PER_PIXEL
) (
   input  logic [MAX_COORD_BITS-1:0] pixel_x,
   input  logic [MAX_COORD_BITS-1:0] pixel_y,
   input  logic [MAX_COORD_BITS:0]   canvas_width,
   input  logic [MAX_COORD_BITS:0]   canvas_height,
   input  logic [MAX_COORD_BITS+2:0] column_stride,
   output logic [ADDR_W-1:0]         byte_address,
   output logic                      in_bounds
);

   localparam int MUL_W = 2 * MAX_COORD_BITS + 3;
   localparam int SUM_W = (MUL_W > ADDR_W) ? MUL_W : ADDR_W;

   logic [SUM_W-1:0] x_term;
   logic [SUM_W-1:0] y_term;
   logic [SUM_W-1:0] addr_sum;

   // Column-major layout: x selects the column, y the pixel in it.
   always_comb begin
      x_term   = SUM_W'(pixel_x) * SUM_W'(column_stride);
      y_term   = SUM_W'(pixel_y) * SUM_W'(BYTES_PER_PIXEL);
      addr_sum = x_term + y_term;
   end

   assign byte_address = addr_sum[ADDR_W-1:0];

   // Clip test against the canvas size.
   assign in_bounds = ({1'b0, pixel_x} < canvas_width) && ({1'b0, pixel_y} < canvas_height);

endmodule

@@ rtl/lr_step.sv @@
`timescale 1ns / 1ps
// Bresenham step unit: one error-term update and one walk move per use.
// Depends on lr_pkg.
module lr_step import lr_pkg::*; #(
   parameter int MAX_COORD_BITS = DEF_MAX_COORD_BITS
) (
   input  logic [MAX_COORD_BITS-1:0]        walk_x,
   input  logic [MAX_COORD_BITS-1:0]        walk_y,
   input  logic signed [MAX_COORD_BITS+1:0] error_term,
   input  logic [MAX_COORD_BITS-1:0]        delta_x,
   input  logic [MAX_COORD_BITS-1:0]        delta_y,
   input  logic                             step_x_negative,
   input  logic                             step_y_negative,
   output logic [MAX_COORD_BITS-1:0]        next_x,
   output logic [MAX_COORD_BITS-1:0]        next_y,
   output logic signed [MAX_COORD_BITS+1:0] next_error
);

   localparam int E_W  = MAX_COORD_BITS + 2;
   localparam int E2_W = MAX_COORD_BITS + 3;

   logic signed [E2_W-1:0] err2;
   logic signed [E2_W-1:0] dx_s;
   logic signed [E2_W-1:0] dy_s;
   logic signed [E2_W-1:0] err_sum;
   logic                   move_x;
   logic                   move_y;

   always_comb begin
      // Doubled error against both deltas decides which axes move.
      err2   = $signed({error_term, 1'b0});
      dx_s   = $signed({3'b000, delta_x});
      dy_s   = $signed({3'b000, delta_y});
      move_x = err2 > -dy_s;
      move_y = err2 < dx_s;

      err_sum = $signed({error_term[E_W-1], error_term});
      if (move_x) begin
         err_sum = err_sum - dy_s;
      end
      if (move_y) begin
         err_sum = err_sum + dx_s;
      end
      next_error = err_sum[E_W-1:0];

      next_x = walk_x;
      if (move_x) begin
         next_x = step_x_negative ? walk_x - 1'b1 : walk_x + 1'b1;
      end
      next_y = walk_y;
      if (move_y) begin
         next_y = step_y_negative ? walk_y - 1'b1 : walk_y + 1'b1;
      end
   end

endmodule

@@ rtl/lr_seq.sv @@
`timescale 1ns / 1ps
// Line sequencer: command setup, end pixel, Bresenham walk and output register.
// Depends on lr_pkg, lr_step and lr_addr.
module lr_seq import lr_pkg::*; #(
   parameter int MAX_COORD_BITS  = DEF_MAX_COORD_BITS,
   parameter int BYTES_PER_PIXEL = DEF_BYTES_PER_PIXEL
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [MAX_COORD_BITS-1:0] req_start_x,
   input  logic [MAX_COORD_BITS-1:0] req_start_y,
   input  logic [MAX_COORD_BITS-1:0] req_end_x,
   input  logic [MAX_COORD_BITS-1:0] req_end_y,
   input  logic [MAX_COORD_BITS:0]   canvas_width,
   input  logic [MAX_COORD_BITS:0]   canvas_height,
   input  logic [MAX_COORD_BITS+2:0] column_stride,
   input  logic [COLOR_W-1:0]        pen_red,
   input  logic [COLOR_W-1:0]        pen_green,
   input  logic [COLOR_W-1:0]        pen_blue,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [MAX_COORD_BITS-1:0] rsp_pixel_x,
   output logic [MAX_COORD_BITS-1:0] rsp_pixel_y,
   output logic [ADDR_W-1:0]         rsp_byte_address,
   output logic [COLOR_W-1:0]        rsp_color_red,
   output logic [COLOR_W-1:0]        rsp_color_green,
   output logic [COLOR_W-1:0]        rsp_color_blue,
   output logic                      rsp_in_bounds,
   output logic                      rsp_last_pixel
);

   localparam int C_W = MAX_COORD_BITS;
   localparam int E_W = MAX_COORD_BITS + 2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT_END,
      ST_WALK
   } state_type;

   state_type              state_ff, state_in;
   logic [C_W-1:0]         walk_x_ff, walk_x_in;
   logic [C_W-1:0]         walk_y_ff, walk_y_in;
   logic signed [E_W-1:0]  err_ff, err_in;
   logic [C_W-1:0]         dx_ff, dx_in;
   logic [C_W-1:0]         dy_ff, dy_in;
   logic                   sxn_ff, sxn_in;
   logic                   syn_ff, syn_in;
   logic [C_W-1:0]         tgt_x_ff, tgt_x_in;
   logic [C_W-1:0]         tgt_y_ff, tgt_y_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [C_W-1:0]         rsp_x_ff, rsp_x_in;
   logic [C_W-1:0]         rsp_y_ff, rsp_y_in;
   logic [ADDR_W-1:0]      rsp_addr_ff, rsp_addr_in;
   logic [COLOR_W-1:0]     rsp_red_ff, rsp_red_in;
   logic [COLOR_W-1:0]     rsp_green_ff, rsp_green_in;
   logic [COLOR_W-1:0]     rsp_blue_ff, rsp_blue_in;
   logic                   rsp_inb_ff, rsp_inb_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   out_free;
   logic                   emit;
   logic [C_W-1:0]         pix_x;
   logic [C_W-1:0]         pix_y;
   logic [ADDR_W-1:0]      pix_addr;
   logic                   pix_inb;
   logic [C_W-1:0]         next_x;
   logic [C_W-1:0]         next_y;
   logic signed [E_W-1:0]  next_err;
   logic                   start_is_end;
   logic                   next_is_end;
   logic                   sxn_new;
   logic                   syn_new;
   logic [C_W-1:0]         dx_new;
   logic [C_W-1:0]         dy_new;

   // Shared Bresenham step unit on the current walk state.
   lr_step #(
      .MAX_COORD_BITS (MAX_COORD_BITS)
   ) u_step (
      .walk_x          (walk_x_ff),
      .walk_y          (walk_y_ff),
      .error_term      (err_ff),
      .delta_x         (dx_ff),
      .delta_y         (dy_ff),
      .step_x_negative (sxn_ff),
      .step_y_negative (syn_ff),
      .next_x          (next_x),
      .next_y          (next_y),
      .next_error      (next_err)
   );

   // The end pixel goes out first, then the walk position.
   assign pix_x = (state_ff == ST_EMIT_END) ? tgt_x_ff : walk_x_ff;
   assign pix_y = (state_ff == ST_EMIT_END) ? tgt_y_ff : walk_y_ff;

   // Shared address and clip unit.
   lr_addr #(
      .MAX_COORD_BITS  (MAX_COORD_BITS),
      .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
   ) u_addr (
      .pixel_x       (pix_x),
      .pixel_y       (pix_y),
      .canvas_width  (canvas_width),
      .canvas_height (canvas_height),
      .column_stride (column_stride),
      .byte_address  (pix_addr),
      .in_bounds     (pix_inb)
   );

   // Command setup values: direction, absolute deltas.
   always_comb begin
      sxn_new = !(req_start_x < req_end_x);
      syn_new = !(req_start_y < req_end_y);
      dx_new  = sxn_new ? req_start_x - req_end_x : req_end_x - req_start_x;
      dy_new  = syn_new ? req_start_y - req_end_y : req_end_y - req_start_y;
   end

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign start_is_end = (walk_x_ff == tgt_x_ff) && (walk_y_ff == tgt_y_ff);
   assign next_is_end  = (next_x == tgt_x_ff) && (next_y == tgt_y_ff);
   assign req_ready    = (state_ff == ST_IDLE);
   assign emit         = out_free && (state_ff != ST_IDLE);

   // Sequencer next-state and output register loading.
   always_comb begin
      state_in     = state_ff;
      walk_x_in    = walk_x_ff;
      walk_y_in    = walk_y_ff;
      err_in       = err_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sxn_in       = sxn_ff;
      syn_in       = syn_ff;
      tgt_x_in     = tgt_x_ff;
      tgt_y_in     = tgt_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_red_in   = rsp_red_ff;
      rsp_green_in = rsp_green_ff;
      rsp_blue_in  = rsp_blue_ff;
      rsp_inb_in   = rsp_inb_ff;
      rsp_last_in  = rsp_last_ff;

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = pix_x;
         rsp_y_in     = pix_y;
         rsp_addr_in  = pix_addr;
         rsp_red_in   = pen_red;
         rsp_green_in = pen_green;
         rsp_blue_in  = pen_blue;
         rsp_inb_in   = pix_inb;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               walk_x_in = req_start_x;
               walk_y_in = req_start_y;
               tgt_x_in  = req_end_x;
               tgt_y_in  = req_end_y;
               sxn_in    = sxn_new;
               syn_in    = syn_new;
               dx_in     = dx_new;
               dy_in     = dy_new;
               err_in    = $signed({2'b00, dx_new}) - $signed({2'b00, dy_new});
               state_in  = ST_EMIT_END;
            end
         end
         ST_EMIT_END: begin
            // A line whose start is its end has only the end pixel.
            if (emit) begin
               rsp_last_in = start_is_end;
               state_in    = start_is_end ? ST_IDLE : ST_WALK;
            end
         end
         ST_WALK: begin
            // The pixel before the end point closes the line.
            if (emit) begin
               rsp_last_in = next_is_end;
               walk_x_in   = next_x;
               walk_y_in   = next_y;
               err_in      = next_err;
               state_in    = next_is_end ? ST_IDLE : ST_WALK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, walk registers and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         walk_x_ff    <= '0;
         walk_y_ff    <= '0;
         err_ff       <= '0;
         dx_ff        <= '0;
         dy_ff        <= '0;
         sxn_ff       <= 1'b0;
         syn_ff       <= 1'b0;
         tgt_x_ff     <= '0;
         tgt_y_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         walk_x_ff    <= walk_x_in;
         walk_y_ff    <= walk_y_in;
         err_ff       <= err_in;
         dx_ff        <= dx_in;
         dy_ff        <= dy_in;
         sxn_ff       <= sxn_in;
         syn_ff       <= syn_in;
         tgt_x_ff     <= tgt_x_in;
         tgt_y_ff     <= tgt_y_in;
      end
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
      rsp_inb_ff   <= rsp_inb_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_x      = rsp_x_ff;
   assign rsp_pixel_y      = rsp_y_ff;
   assign rsp_byte_address = rsp_addr_ff;
   assign rsp_color_red    = rsp_red_ff;
   assign rsp_color_green  = rsp_green_ff;
   assign rsp_color_blue   = rsp_blue_ff;
   assign rsp_in_bounds    = rsp_inb_ff;
   assign rsp_last_pixel   = rsp_last_ff;

   // An accepted command always starts with the end pixel.
   a_accept_starts_line: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EMIT_END))
      else $error("accepted command did not start the end pixel");

   // The walk finishes before it reaches the end point, so it never sits there.
   a_walk_not_at_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> !((walk_x_ff == tgt_x_ff) && (walk_y_ff == tgt_y_ff)))
      else $error("walk position reached the end point without finishing the line");

   // Loading the final pixel returns the sequencer to idle with a pending result.
   a_last_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (emit && rsp_last_in) |=> ((state_ff == ST_IDLE) && rsp_valid_ff && rsp_last_ff))
      else $error("final pixel did not close the line");

endmodule

@@ rtl/line_rasterizer_top.sv @@
`timescale 1ns / 1ps
// Line rasterizer top level: a command of N = 1 + max(|dx|, |dy|) pixels (at most 64)
// produces the end pixel as its first write, then one pixel per cycle while the result
// side is ready; back-pressure stalls the walk. The Bresenham step unit and the address
// unit are used once per pixel.
// Synchronous active-high reset: idle, canvas 64 x 64, pen color 0. No clearing pass.
module line_rasterizer_top import lr_pkg::*; #(
   parameter int MAX_COORD_BITS  = DEF_MAX_COORD_BITS,
   parameter int BYTES_PER_PIXEL = DEF_BYTES_PER_PIXEL
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Line commands.
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [MAX_COORD_BITS-1:0]              req_start_x,
   input  logic [MAX_COORD_BITS-1:0]              req_start_y,
   input  logic [MAX_COORD_BITS-1:0]              req_end_x,
   input  logic [MAX_COORD_BITS-1:0]              req_end_y,
   // Pixel writes.
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [MAX_COORD_BITS-1:0]              rsp_pixel_x,
   output logic [MAX_COORD_BITS-1:0]              rsp_pixel_y,
   output logic [ADDR_W-1:0]                      rsp_byte_address,
   output logic [COLOR_W-1:0]                     rsp_color_red,
   output logic [COLOR_W-1:0]                     rsp_color_green,
   output logic [COLOR_W-1:0]                     rsp_color_blue,
   output logic                                   rsp_in_bounds,
   output logic                                   rsp_last_pixel,
   // Configuration writes.
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [CSR_IDX_W-1:0]                   csr_index,
   input  logic [csr_data_w(MAX_COORD_BITS)-1:0]  csr_wdata
);

   logic [MAX_COORD_BITS:0]   canvas_width;
   logic [MAX_COORD_BITS:0]   canvas_height;
   logic [MAX_COORD_BITS+2:0] column_stride;
   logic [COLOR_W-1:0]        pen_red;
   logic [COLOR_W-1:0]        pen_green;
   logic [COLOR_W-1:0]        pen_blue;

   // Configuration registers.
   lr_csr #(
      .MAX_COORD_BITS  (MAX_COORD_BITS),
      .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
   ) u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .canvas_width  (canvas_width),
      .canvas_height (canvas_height),
      .column_stride (column_stride),
      .pen_red       (pen_red),
      .pen_green     (pen_green),
      .pen_blue      (pen_blue)
   );

   // Line sequencer with the shared step and address units.
   lr_seq #(
      .MAX_COORD_BITS  (MAX_COORD_BITS),
      .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .canvas_width     (canvas_width),
      .canvas_height    (canvas_height),
      .column_stride    (column_stride),
      .pen_red          (pen_red),
      .pen_green        (pen_green),
      .pen_blue         (pen_blue),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_byte_address (rsp_byte_address),
      .rsp_color_red    (rsp_color_red),
      .rsp_color_green  (rsp_color_green),
      .rsp_color_blue   (rsp_color_blue),
      .rsp_in_bounds    (rsp_in_bounds),
      .rsp_last_pixel   (rsp_last_pixel)
   );

endmodule
